@@ src/clbr_pkg.sv @@
`default_nettype none
package clbr_pkg;

   localparam int DATA_W = 16;
   localparam int FRAC_BITS = 8;
   localparam int ADDR_W = 16;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [1:0] {
      ACT_LOAD_FEAT  = 2'd0,
      ACT_LOAD_PARAM = 2'd1,
      ACT_COMPUTE    = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUT_CH   = 3'd0,
      CSR_IN_CH    = 3'd1,
      CSR_KERNEL   = 3'd2,
      CSR_IN_SIDE  = 3'd3,
      CSR_OUT_SIDE = 3'd4,
      CSR_STEP     = 3'd5,
      CSR_PAD      = 3'd6,
      CSR_POST     = 3'd7
   } csr_idx_type;

   typedef struct packed {
      action_type         action;
      logic [ADDR_W-1:0]  address;
      logic [DATA_W-1:0]  value;
      logic [8:0]         oc;
      logic [7:0]         orow;
      logic [7:0]         ocol;
   } req_type;

   typedef struct packed {
      logic [9:0] out_ch;
      logic [9:0] in_ch;
      logic [2:0] kernel;
      logic [8:0] in_side;
      logic [8:0] out_side;
      logic [2:0] step;
      logic       pad;
      logic [1:0] post;
   } cfg_type;

endpackage
`default_nettype wire

@@ src/clbr_front.sv @@
`default_nettype none
module clbr_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   output logic                   full,
   input  wire  clbr_pkg::req_type req,
   output logic                   q_valid,
   output clbr_pkg::req_type      q_req,
   input  wire                    q_take
);
   import clbr_pkg::*;

   req_type    slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       enq, deq;

   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_req   = slot_ff[rptr_ff];

   // unused action codes are dropped here
   assign enq = push && !full && (req.action != ACT_NONE);
   assign deq = q_take && q_valid;

   always_comb begin
      wptr_in = enq ? !wptr_ff : wptr_ff;
      rptr_in = deq ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (enq) begin
         slot_ff[wptr_ff] <= req;
      end
   end

endmodule
`default_nettype wire

@@ src/clbr_back.sv @@
`default_nettype none
module clbr_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  clbr_pkg::cfg_type cfg,
   input  wire                    q_valid,
   input  wire  clbr_pkg::req_type q_req,
   output logic                   q_take,
   output logic                   res_valid,
   output logic [clbr_pkg::DATA_W-1:0] res_value,
   input  wire                    res_pop
);
   import clbr_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_SETUP1 = 10'b0000000010,
      S_SETUP2 = 10'b0000000100,
      S_TAP    = 10'b0000001000,
      S_MAC    = 10'b0000010000,
      S_DRAIN  = 10'b0000100000,
      S_BIAS   = 10'b0001000000,
      S_SCALE  = 10'b0010000000,
      S_SHIFT  = 10'b0100000000,
      S_RESULT = 10'b1000000000
   } state_type;

   logic [DATA_W-1:0] fmem [MEM_DEPTH];
   logic [DATA_W-1:0] pmem [MEM_DEPTH];

   state_type st_ff, st_in;
   logic [8:0]  oc_ff, oc_in;
   logic [7:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   logic [5:0]  kk_ff, kk_in, ktap_ff, ktap_in;
   logic [ADDR_W-1:0] ss_ff, ss_in, ocic_ff, ocic_in, chic_ff, chic_in;
   logic [ADDR_W-1:0] wbase_ff, wbase_in, base_ff, base_in;
   logic signed [11:0] r0_ff, r0_in, c0_ff, c0_in;
   logic [2:0]  kr_ff, kr_in, kc_ff, kc_in;
   logic [9:0]  ci_ff, ci_in;
   logic        tapok_ff, tapok_in;
   logic [ADDR_W-1:0] fi_ff, fi_in, wi_ff, wi_in;
   logic        v1_ff, v2_ff;
   logic [DATA_W-1:0] frd_ff, prd_ff;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] acc_ff, acc_in, res_ff, res_in;
   logic        rvalid_ff, rvalid_in;

   logic [1:0]  pad;
   logic [12:0] r, c;
   logic [18:0] fi0;
   logic        issue;
   logic [ADDR_W-1:0] sc_addr, praddr;
   logic [DATA_W-1:0] opa, prod_q;
   logic [3:0]  kc_next;

   assign q_take    = (st_ff == S_IDLE) && q_valid;
   assign res_valid = rvalid_ff;
   assign res_value = res_ff;

   assign pad     = (cfg.pad && cfg.kernel != 3'd0) ? 2'((cfg.kernel - 3'd1) >> 1) : 2'd0;
   assign r       = {r0_ff[11], r0_ff} + {10'd0, kr_ff};
   assign c       = {c0_ff[11], c0_ff} + {10'd0, kc_ff};
   assign fi0     = 19'(r[8:0] * cfg.in_side) + {10'd0, c[8:0]};
   assign issue   = (st_ff == S_MAC) && tapok_ff && (ci_ff < cfg.in_ch);
   assign sc_addr = base_ff + {6'd0, cfg.out_ch} + {6'd0, oc_ff, 1'b0};
   assign opa     = (st_ff == S_SCALE) ? acc_ff : frd_ff;
   assign prod_in = $signed(opa) * $signed(prd_ff);
   assign prod_q  = prod_ff[FRAC_BITS +: DATA_W];
   assign kc_next = {1'b0, kc_ff} + 4'd1;

   always_comb begin
      unique case (st_ff)
         S_DRAIN: praddr = base_ff + {7'd0, oc_ff};
         S_BIAS:  praddr = sc_addr;
         S_SCALE: praddr = sc_addr + 16'd1;
         default: praddr = wi_ff;
      endcase
   end

   always_comb begin
      st_in = st_ff;
      oc_in = oc_ff; orow_in = orow_ff; ocol_in = ocol_ff;
      kk_in = kk_ff; ss_in = ss_ff; ocic_in = ocic_ff; chic_in = chic_ff;
      r0_in = r0_ff; c0_in = c0_ff; wbase_in = wbase_ff; base_in = base_ff;
      kr_in = kr_ff; kc_in = kc_ff; ktap_in = ktap_ff; ci_in = ci_ff;
      tapok_in = tapok_ff; fi_in = fi_ff; wi_in = wi_ff;
      acc_in = acc_ff; res_in = res_ff;
      rvalid_in = rvalid_ff && !res_pop;
      if (v2_ff) begin
         acc_in = acc_ff + prod_q;
      end
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid && q_req.action == ACT_COMPUTE) begin
               oc_in   = q_req.oc;
               orow_in = q_req.orow;
               ocol_in = q_req.ocol;
               st_in   = S_SETUP1;
            end
         end
         S_SETUP1: begin
            kk_in   = 6'(cfg.kernel * cfg.kernel);
            ss_in   = 16'(cfg.in_side * cfg.in_side);
            ocic_in = 16'(oc_ff * cfg.in_ch);
            chic_in = 16'(cfg.out_ch * cfg.in_ch);
            r0_in   = $signed({1'b0, 11'(orow_ff * cfg.step)}) - $signed({10'd0, pad});
            c0_in   = $signed({1'b0, 11'(ocol_ff * cfg.step)}) - $signed({10'd0, pad});
            acc_in  = '0;
            st_in   = S_SETUP2;
         end
         S_SETUP2: begin
            wbase_in = 16'(ocic_ff * kk_ff);
            base_in  = 16'(chic_ff * kk_ff);
            kr_in    = '0;
            kc_in    = '0;
            ktap_in  = '0;
            st_in    = S_TAP;
         end
         S_TAP: begin
            if (kr_ff == cfg.kernel) begin
               st_in = S_DRAIN;
            end else begin
               tapok_in = !r[12] && !c[12] && (r[11:0] < {3'd0, cfg.in_side})
                          && (c[11:0] < {3'd0, cfg.in_side});
               fi_in    = fi0[ADDR_W-1:0];
               wi_in    = wbase_ff + {10'd0, ktap_ff};
               ci_in    = '0;
               st_in    = S_MAC;
            end
         end
         S_MAC: begin
            if (issue) begin
               fi_in = fi_ff + ss_ff;
               wi_in = wi_ff + {10'd0, kk_ff};
               ci_in = ci_ff + 10'd1;
            end else begin
               if (kc_next == {1'b0, cfg.kernel}) begin
                  kc_in = '0;
                  kr_in = kr_ff + 3'd1;
               end else begin
                  kc_in = kc_next[2:0];
               end
               ktap_in = ktap_ff + 6'd1;
               st_in   = S_TAP;
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               st_in = S_BIAS;
            end
         end
         S_BIAS: begin
            acc_in = acc_ff + prd_ff;
            st_in  = cfg.post[0] ? S_SCALE : S_RESULT;
         end
         S_SCALE: begin
            st_in = S_SHIFT;
         end
         S_SHIFT: begin
            acc_in = prod_q + prd_ff;
            st_in  = S_RESULT;
         end
         S_RESULT: begin
            if (!rvalid_ff || res_pop) begin
               res_in    = (cfg.post[1] && acc_ff[DATA_W-1]) ? '0 : acc_ff;
               rvalid_in = 1'b1;
               st_in     = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         v1_ff     <= issue;
         v2_ff     <= v1_ff;
         rvalid_ff <= rvalid_in;
      end
      oc_ff <= oc_in; orow_ff <= orow_in; ocol_ff <= ocol_in;
      kk_ff <= kk_in; ss_ff <= ss_in; ocic_ff <= ocic_in; chic_ff <= chic_in;
      r0_ff <= r0_in; c0_ff <= c0_in; wbase_ff <= wbase_in; base_ff <= base_in;
      kr_ff <= kr_in; kc_ff <= kc_in; ktap_ff <= ktap_in; ci_ff <= ci_in;
      tapok_ff <= tapok_in; fi_ff <= fi_in; wi_ff <= wi_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (q_take && q_req.action == ACT_LOAD_FEAT) begin
         fmem[q_req.address] <= q_req.value;
      end
      frd_ff <= fmem[fi_ff];
   end

   always_ff @(posedge clock) begin
      if (q_take && q_req.action == ACT_LOAD_PARAM) begin
         pmem[q_req.address] <= q_req.value;
      end
      prd_ff <= pmem[praddr];
   end

endmodule
`default_nettype wire

@@ src/conv_layer_bn_relu.sv @@
`default_nettype none
// channel   ports                                   handshake
// request   req_action/address/load_value/out_*     req_push, req_full
// response  rsp_result_value                        rsp_pop, rsp_empty
// csr       csr_index, csr_data                     csr_write
//
// Requests leave the queue only while the engine is idle, so a compute request
// finishes before the next is taken; its taps, and the batch-norm scale and
// shift, run through the single multiply-accumulate path on the two memory
// read ports. A response that is not popped holds the engine.
// Reset is synchronous; memories are not cleared and need loading first.
// A 2-entry queue lets requests land while a compute runs or a response waits.
module conv_layer_bn_relu (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   output logic        req_full,
   input  wire  [1:0]  req_action,
   input  wire  [15:0] req_address,
   input  wire  signed [15:0] req_load_value,
   input  wire  [8:0]  req_out_channel,
   input  wire  [7:0]  req_out_row,
   input  wire  [7:0]  req_out_col,
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic signed [15:0] rsp_result_value,
   input  wire         csr_write,
   input  wire  [clbr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [clbr_pkg::CSR_DATA_W-1:0] csr_data
);
   import clbr_pkg::*;

   cfg_type    cfg_ff;
   req_type    req, q_req;
   logic       q_valid, q_take, res_valid;
   logic [DATA_W-1:0] res_value;

   assign req.action  = action_type'(req_action);
   assign req.address = req_address;
   assign req.value   = req_load_value;
   assign req.oc      = req_out_channel;
   assign req.orow    = req_out_row;
   assign req.ocol    = req_out_col;

   assign rsp_empty        = !res_valid;
   assign rsp_result_value = res_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_ch   <= 10'd1;
         cfg_ff.in_ch    <= 10'd1;
         cfg_ff.kernel   <= 3'd3;
         cfg_ff.in_side  <= 9'd1;
         cfg_ff.out_side <= 9'd1;
         cfg_ff.step     <= 3'd1;
         cfg_ff.pad      <= 1'b0;
         cfg_ff.post     <= 2'd0;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_OUT_CH:   cfg_ff.out_ch   <= csr_data;
            CSR_IN_CH:    cfg_ff.in_ch    <= csr_data;
            CSR_KERNEL:   cfg_ff.kernel   <= csr_data[2:0];
            CSR_IN_SIDE:  cfg_ff.in_side  <= csr_data[8:0];
            CSR_OUT_SIDE: cfg_ff.out_side <= csr_data[8:0];
            CSR_STEP:     cfg_ff.step     <= csr_data[2:0];
            CSR_PAD:      cfg_ff.pad      <= csr_data[0];
            CSR_POST:     cfg_ff.post     <= csr_data[1:0];
            default:      cfg_ff.post     <= cfg_ff.post;
         endcase
      end
   end

   clbr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .req     (req),
      .q_valid (q_valid),
      .q_req   (q_req),
      .q_take  (q_take)
   );

   clbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_req     (q_req),
      .q_take    (q_take),
      .res_valid (res_valid),
      .res_value (res_value),
      .res_pop   (rsp_pop)
   );

endmodule
`default_nettype wire

@@ bench/tb_conv_layer_bn_relu.sv @@
`timescale 1ns / 1ps
module tb_conv_layer_bn_relu;
   import clbr_pkg::*;

   typedef struct {
      action_type  action;
      logic [15:0] address;
      logic [15:0] value;
      logic [8:0]  oc;
      logic [7:0]  orow;
      logic [7:0]  ocol;
      bit          has_exp;
      logic [15:0] exp_v;
   } req_row_type;

   typedef struct {
      cfg_type c;
      int      n;
   } phase_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_action;
   logic [15:0] req_address;
   logic signed [15:0] req_load_value;
   logic [8:0]  req_out_channel;
   logic [7:0]  req_out_row;
   logic [7:0]  req_out_col;
   logic        rsp_empty;
   logic        rsp_pop;
   logic signed [15:0] rsp_result_value;
   logic        csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // typed expectation travels with the request
   logic        typed_v;
   logic [15:0] typed_val;

   bit [15:0] feat_mem [0:65535];
   bit [15:0] par_mem [0:65535];
   bit        feat_set [0:65535];
   bit        par_set [0:65535];
   logic [15:0] feat_reads [$];
   logic [15:0] par_reads [$];
   logic [15:0] pixel_q [$];
   cfg_type   cfg_now;
   int        errors = 0;
   int        sent_cnt = 0;
   int        sidle_pct = 0;
   int        ridle_pct = 0;

   conv_layer_bn_relu dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_action(req_action), .req_address(req_address),
      .req_load_value(req_load_value), .req_out_channel(req_out_channel),
      .req_out_row(req_out_row), .req_out_col(req_out_col),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_result_value(rsp_result_value),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [15:0] qmul(logic [15:0] a, logic [15:0] b);
      logic signed [31:0] p;
      p = $signed(a) * $signed(b);
      return p[23:8];
   endfunction

   function automatic logic [15:0] feat_rd(logic [15:0] a, bit track);
      if (track) feat_reads.push_back(a);
      return feat_mem[a];
   endfunction

   function automatic logic [15:0] par_rd(logic [15:0] a, bit track);
      if (track) par_reads.push_back(a);
      return par_mem[a];
   endfunction

   function automatic logic [15:0] conv_pixel(logic [8:0] oc, logic [7:0] orow,
                                              logic [7:0] ocol, bit track);
      int k, kk, pad, r0, c0, r, c, side, ic, fi, wi, base, bn;
      logic [15:0] acc;
      k = cfg_now.kernel;
      kk = k * k;
      side = cfg_now.in_side;
      ic = cfg_now.in_ch;
      pad = (cfg_now.pad && k >= 1) ? (k - 1) / 2 : 0;
      r0 = int'(orow) * int'(cfg_now.step) - pad;
      c0 = int'(ocol) * int'(cfg_now.step) - pad;
      acc = '0;
      for (int kr = 0; kr < k; kr++) begin
         for (int kc = 0; kc < k; kc++) begin
            r = r0 + kr;
            c = c0 + kc;
            if (r < 0 || c < 0 || r >= side || c >= side) continue;
            for (int ci = 0; ci < ic; ci++) begin
               fi = ci * side * side + r * side + c;
               wi = int'(oc) * ic * kk + ci * kk + kr * k + kc;
               acc = acc + qmul(feat_rd(fi[15:0], track), par_rd(wi[15:0], track));
            end
         end
      end
      base = int'(cfg_now.out_ch) * ic * kk;
      wi = base + int'(oc);
      acc = acc + par_rd(wi[15:0], track);
      if (cfg_now.post[0]) begin
         bn = base + int'(cfg_now.out_ch) + 2 * int'(oc);
         acc = qmul(acc, par_rd(bn[15:0], track));
         bn = bn + 1;
         acc = acc + par_rd(bn[15:0], track);
      end
      if (cfg_now.post[1] && acc[15]) acc = '0;
      return acc;
   endfunction

   function automatic logic [15:0] rand_val();
      if ($urandom_range(1)) return 16'($urandom);
      return 16'($urandom_range(1023) - 512);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_req(action_type a, logic [15:0] addr, logic [15:0] val,
                           logic [8:0] oc, logic [7:0] orow, logic [7:0] ocol,
                           bit has_exp, logic [15:0] exp_v);
      while ($urandom_range(99) < sidle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_action <= a;
      req_address <= addr;
      req_load_value <= val;
      req_out_channel <= oc;
      req_out_row <= orow;
      req_out_col <= ocol;
      typed_v <= has_exp;
      typed_val <= exp_v;
      if (a == ACT_LOAD_FEAT) feat_set[addr] = 1'b1;
      if (a == ACT_LOAD_PARAM) par_set[addr] = 1'b1;
      sent_cnt++;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   // load every operand of a pixel that has not been written yet
   task automatic fill_reads(logic [8:0] oc, logic [7:0] orow, logic [7:0] ocol);
      logic [15:0] unused;
      logic [15:0] a;
      feat_reads.delete();
      par_reads.delete();
      unused = conv_pixel(oc, orow, ocol, 1'b1);
      foreach (feat_reads[i]) begin
         a = feat_reads[i];
         if (!feat_set[a]) send_req(ACT_LOAD_FEAT, a, rand_val(), '0, '0, '0, 1'b0, '0);
      end
      foreach (par_reads[i]) begin
         a = par_reads[i];
         if (!par_set[a]) send_req(ACT_LOAD_PARAM, a, rand_val(), '0, '0, '0, 1'b0, '0);
      end
   endtask

   task automatic apply_cfg(cfg_type c);
      logic [9:0] vals [8];
      vals = '{c.out_ch, c.in_ch, 10'(c.kernel), 10'(c.in_side), 10'(c.out_side),
               10'(c.step), 10'(c.pad), 10'(c.post)};
      csr_write <= 1'b1;
      for (int i = 0; i < 8; i++) begin
         csr_index <= csr_idx_type'(i);
         csr_data <= vals[i];
         @(negedge clock);
      end
      csr_write <= 1'b0;
      cfg_now = c;
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_item();
      int sel, lim;
      logic [8:0] oc;
      logic [7:0] orow, ocol;
      logic [15:0] addr;
      sel = $urandom_range(99);
      if (sel < 40) begin
         lim = (cfg_now.out_ch == 0) ? 0 : ((cfg_now.out_ch > 512) ? 511 : cfg_now.out_ch - 1);
         oc = ($urandom_range(99) < 80) ? 9'($urandom_range(lim)) : 9'($urandom);
         lim = (cfg_now.out_side == 0) ? 0 :
               ((cfg_now.out_side > 256) ? 255 : cfg_now.out_side - 1);
         orow = ($urandom_range(99) < 85) ? 8'($urandom_range(lim)) : 8'($urandom);
         ocol = ($urandom_range(99) < 85) ? 8'($urandom_range(lim)) : 8'($urandom);
         fill_reads(oc, orow, ocol);
         send_req(ACT_COMPUTE, 16'($urandom), 16'($urandom), oc, orow, ocol, 1'b0, '0);
      end else if (sel < 65) begin
         addr = (feat_reads.size() != 0 && $urandom_range(1)) ?
                feat_reads[$urandom_range(feat_reads.size() - 1)] : 16'($urandom);
         send_req(ACT_LOAD_FEAT, addr, rand_val(), 9'($urandom), 8'($urandom),
                  8'($urandom), 1'b0, '0);
      end else if (sel < 90) begin
         addr = (par_reads.size() != 0 && $urandom_range(1)) ?
                par_reads[$urandom_range(par_reads.size() - 1)] : 16'($urandom);
         send_req(ACT_LOAD_PARAM, addr, rand_val(), 9'($urandom), 8'($urandom),
                  8'($urandom), 1'b0, '0);
      end else begin
         send_req(ACT_NONE, 16'($urandom), 16'($urandom), 9'($urandom), 8'($urandom),
                  8'($urandom), 1'b0, '0);
      end
   endtask

   // scoreboard: predictor runs on accepted requests, responses checked in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            case (action_type'(req_action))
               ACT_LOAD_FEAT: feat_mem[req_address] = req_load_value;
               ACT_LOAD_PARAM: par_mem[req_address] = req_load_value;
               ACT_COMPUTE: pixel_q.push_back(typed_v ? typed_val :
                  conv_pixel(req_out_channel, req_out_row, req_out_col, 1'b0));
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (pixel_q.size() == 0) begin
               $error("result_value: unexpected response %h", rsp_result_value);
               errors++;
            end else begin
               if (rsp_result_value !== pixel_q[0]) begin
                  $error("result_value: expected %h actual %h", pixel_q[0], rsp_result_value);
                  errors++;
               end
               void'(pixel_q.pop_front());
            end
         end
      end
   end

   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop <= ($urandom_range(99) >= ridle_pct);
      end
   end

   initial begin
      #40000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      req_row_type rows [$];
      phase_type phases [$];
      cfg_type dcfg;
      int goal;
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_action = ACT_NONE;
      req_address = '0;
      req_load_value = '0;
      req_out_channel = '0;
      req_out_row = '0;
      req_out_col = '0;
      csr_write = 1'b0;
      csr_index = CSR_OUT_CH;
      csr_data = '0;
      typed_v = 1'b0;
      typed_val = '0;
      cfg_now = '{10'd1, 10'd1, 3'd3, 9'd1, 9'd1, 3'd1, 1'b0, 2'd0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: 2 out ch, 1 in ch, 1x1 kernel, 2x2 map -> bias base at 2
      dcfg = '{10'd2, 10'd1, 3'd1, 9'd2, 9'd2, 3'd1, 1'b0, 2'd0};
      apply_cfg(dcfg);
      rows = '{
         '{ACT_LOAD_FEAT,  16'h0000, 16'h0100, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_LOAD_PARAM, 16'h0000, 16'h0200, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_LOAD_PARAM, 16'h0002, 16'h0080, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_COMPUTE,    16'h0000, 16'h0000, 9'd0,   8'd0,   8'd0,   1, 16'h0280},
         '{ACT_LOAD_PARAM, 16'h0201, 16'h7fff, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_COMPUTE,    16'hffff, 16'hffff, 9'd511, 8'd255, 8'd255, 1, 16'h7fff},
         '{ACT_LOAD_FEAT,  16'hffff, 16'h8000, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_LOAD_PARAM, 16'hffff, 16'hffff, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_NONE,       16'hffff, 16'h7fff, 9'd511, 8'd255, 8'd255, 0, 16'h0000},
         '{ACT_LOAD_FEAT,  16'h0001, 16'h8000, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_COMPUTE,    16'h0000, 16'h0000, 9'd0,   8'd0,   8'd1,   1, 16'h0080},
         '{ACT_LOAD_FEAT,  16'h0002, 16'h7fff, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_LOAD_FEAT,  16'h0003, 16'hffff, 9'd0,   8'd0,   8'd0,   0, 16'h0000},
         '{ACT_COMPUTE,    16'h0000, 16'h0000, 9'd1,   8'd1,   8'd0,   0, 16'h0000},
         '{ACT_COMPUTE,    16'h0000, 16'h0000, 9'd0,   8'd1,   8'd1,   0, 16'h0000}
      };
      foreach (rows[i]) begin
         if (rows[i].action == ACT_COMPUTE)
            fill_reads(rows[i].oc, rows[i].orow, rows[i].ocol);
         send_req(rows[i].action, rows[i].address, rows[i].value, rows[i].oc,
                  rows[i].orow, rows[i].ocol, rows[i].has_exp, rows[i].exp_v);
      end
      drain();

      // n is the request budget of a phase, operand loads included
      phases = '{
         '{'{10'd4,    10'd3,   3'd3, 9'd8,   9'd8,   3'd1, 1'b1, 2'd3}, 100},
         '{'{10'd2,    10'd2,   3'd5, 9'd6,   9'd6,   3'd2, 1'b1, 2'd1}, 100},
         '{'{10'd1,    10'd1,   3'd7, 9'd16,  9'd4,   3'd4, 1'b1, 2'd2}, 100},
         '{'{10'd3,    10'd4,   3'd2, 9'd5,   9'd5,   3'd3, 1'b0, 2'd3}, 100},
         '{'{10'd512,  10'd64,  3'd1, 9'd2,   9'd2,   3'd1, 1'b0, 2'd3}, 40},
         '{'{10'd1,    10'd1,   3'd7, 9'd256, 9'd256, 3'd4, 1'b1, 2'd3}, 100},
         '{'{10'd0,    10'd0,   3'd0, 9'd0,   9'd0,   3'd0, 1'b0, 2'd0}, 100},
         '{'{10'd5,    10'd2,   3'd3, 9'd7,   9'd7,   3'd0, 1'b1, 2'd1}, 100},
         '{'{10'd1023, 10'd1,   3'd7, 9'd511, 9'd511, 3'd7, 1'b1, 2'd3}, 100}
      };
      foreach (phases[p]) begin
         case (p % 4)
            0: begin sidle_pct = 0;  ridle_pct = 0;  end
            1: begin sidle_pct = 51; ridle_pct = 0;  end
            2: begin sidle_pct = 0;  ridle_pct = 51; end
            default: begin sidle_pct = 26; ridle_pct = 26; end
         endcase
         apply_cfg(phases[p].c);
         feat_reads.delete();
         par_reads.delete();
         goal = sent_cnt + phases[p].n;
         while (sent_cnt < goal) random_item();
         drain();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
